// ----- design/assert_macros.svh -----
// Assertion macros shared by the deframer checker.
// Depends on nothing; take it in with a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("deframer check failed");

// Clocked property that also holds through reset.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("deframer check failed");

`endif

// ----- design/lpd_pkg.sv -----
// Types, constants and ring helpers for the length-prefixed deframer.
// Used by every module of the block; depends on nothing.
package lpd_pkg;

  localparam int BUF_DEPTH  = 4096;
  localparam int ADDR_W     = $clog2(BUF_DEPTH);
  localparam int FILL_W     = $clog2(BUF_DEPTH + 1);
  localparam int HDR_BYTES  = 4;
  localparam int LEN_W      = 17;
  localparam int STATUS_W   = 3;
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(4096);

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_BYTE      = 3'd0,
    ST_NOT_READY = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_FULL      = 3'd3,
    ST_WRITE_OK  = 3'd4
  } status_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    status_t           status;
    logic [7:0]        packet_byte;
    logic [LEN_W-1:0]  packet_length;
    logic              last;
  } result_t;

  // Ring index p + k, with k below the depth.
  function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] p,
                                                 input logic [ADDR_W-1:0] k);
    logic [ADDR_W:0] sum;
    sum = {1'b0, p} + {1'b0, k};
    if (sum >= (ADDR_W+1)'(BUF_DEPTH)) begin
      sum = sum - (ADDR_W+1)'(BUF_DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

// ----- design/length_prefixed_packet_deframer_core.sv -----
// Length-prefixed packet deframer, top level.
// Depends on lpd_pkg, lpd_store, lpd_ctrl and lpd_out.
//
// Item channel (item_valid / item_stall): one word per accepted item. operation
// 0 stores data_byte in a 4096-byte ring; 1 asks for the next byte of a complete
// packet. A packet opens with a 4-byte big-endian signed length counting itself.
// Result channel (result_valid / result_stall): exactly one word per item, with
// status, packet_byte, packet_length and last.
// Each result is registered in the output stage, or in the skid stage while stalled.
// Throughput: one item per cycle while item_stall is low, set by the single
// store read port; a read that consumes a byte with more than four held fetches
// the byte four places ahead, which enters the header window on the next cycle.
// Stall: a skid stage takes one result while the receiver stalls; item_stall
// rises only when that stage is also full, and falls once it drains.
// Configuration: max_packet_length is written over cfg_valid / cfg_ready,
// which is always ready; write it only while the block is idle.
// Reset: pointers, fill count and packet state clear, the limit returns to
// 4096 and both channels go empty. The store itself is not cleared, so no
// clearing pass is needed.
module length_prefixed_packet_deframer_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  output logic                      item_stall,
  input  logic                      operation,
  input  logic [7:0]                data_byte,
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic [lpd_pkg::STATUS_W-1:0] status,
  output logic [7:0]                packet_byte,
  output logic [lpd_pkg::LEN_W-1:0] packet_length,
  output logic                      last,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [lpd_pkg::LEN_W-1:0] max_packet_length
);

  logic                      accept;
  logic [lpd_pkg::LEN_W-1:0] max_len;
  lpd_pkg::mem_req_t         req;
  logic [7:0]                rd_data;
  lpd_pkg::result_t          res;
  lpd_pkg::result_t          result;

  // Take an item whenever the skid stage has room.
  assign accept    = item_valid && !item_stall;
  assign cfg_ready = 1'b1;

  // Hold the packet length limit; load it on each configuration word.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= lpd_pkg::MAX_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_len <= max_packet_length;
    end
  end

  lpd_store u_store (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  lpd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .operation (operation),
    .data_byte (data_byte),
    .max_len   (max_len),
    .rd_data   (rd_data),
    .req       (req),
    .res       (res)
  );

  lpd_out u_out (
    .clk          (clk),
    .rst          (rst),
    .res_valid    (accept),
    .res          (res),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result),
    .item_stall   (item_stall)
  );

  // Drive the payload ports from the output register.
  assign status        = result.status;
  assign packet_byte   = result.packet_byte;
  assign packet_length = result.packet_length;
  assign last          = result.last;

endmodule

// ----- design/lpd_store.sv -----
// Byte store of the deframer: one write port, one read port, registered read.
// Depends on lpd_pkg.
module lpd_store (
  input  logic              clk,
  input  lpd_pkg::mem_req_t req,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [lpd_pkg::BUF_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

// ----- design/lpd_ctrl.sv -----
// Deframer control: pointers, fill count, header window and packet decision.
// Depends on lpd_pkg; drives the byte store and the output stage.
module lpd_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  logic                     operation,
  input  logic [7:0]               data_byte,
  input  logic [lpd_pkg::LEN_W-1:0] max_len,
  input  logic [7:0]               rd_data,
  output lpd_pkg::mem_req_t        req,
  output lpd_pkg::result_t         res
);

  localparam int AW = lpd_pkg::ADDR_W;
  localparam int FW = lpd_pkg::FILL_W;
  localparam int LW = lpd_pkg::LEN_W;

  // The window holds the bytes at read_pointer .. read_pointer+3 (as many as held).
  logic [7:0]    win      [lpd_pkg::HDR_BYTES];
  logic [7:0]    win_next [lpd_pkg::HDR_BYTES];
  logic [7:0]    eff      [lpd_pkg::HDR_BYTES];
  logic          pend, pend_next;
  logic [AW-1:0] read_pointer, read_pointer_next;
  logic [AW-1:0] write_pointer, write_pointer_next;
  logic [FW-1:0] fill_count, fill_count_next;
  logic [LW-1:0] bytes_remaining, bytes_remaining_next;
  logic [LW-1:0] current_length, current_length_next;

  logic [31:0]   hdr;
  logic          consume;
  logic [LW-1:0] len_sel;
  logic [LW-1:0] rem_sel;
  logic          hdr_too_big;
  logic          hdr_short_fill;

  always_comb begin
    eff[0] = win[0];
    eff[1] = win[1];
    eff[2] = win[2];
    eff[3] = pend ? rd_data : win[3];
  end

  assign hdr = {eff[0], eff[1], eff[2], eff[3]};
  assign hdr_too_big = (hdr[31:LW] != '0) || (hdr[LW-1:0] >= max_len);
  assign hdr_short_fill = (hdr[31:FW] != '0) || (hdr[FW-1:0] > fill_count);

  always_comb begin
    win_next             = eff;
    pend_next            = 1'b0;
    read_pointer_next    = read_pointer;
    write_pointer_next   = write_pointer;
    fill_count_next      = fill_count;
    bytes_remaining_next = bytes_remaining;
    current_length_next  = current_length;
    req                  = '0;
    res                  = '0;
    res.status           = lpd_pkg::ST_NOT_READY;
    consume              = 1'b0;
    len_sel              = current_length;
    rem_sel              = bytes_remaining;

    if (accept) begin
      unique case (lpd_pkg::op_t'(operation))
        lpd_pkg::OP_WRITE: begin
          if (fill_count == FW'(lpd_pkg::BUF_DEPTH)) begin
            res.status = lpd_pkg::ST_FULL;
          end else begin
            req.we             = 1'b1;
            req.waddr          = write_pointer;
            req.wdata          = data_byte;
            write_pointer_next = lpd_pkg::ring_add(write_pointer, AW'(1));
            fill_count_next    = fill_count + FW'(1);
            if (fill_count < FW'(lpd_pkg::HDR_BYTES)) begin
              win_next[fill_count[1:0]] = data_byte;
            end
            res.status = lpd_pkg::ST_WRITE_OK;
          end
        end
        lpd_pkg::OP_READ: begin
          if (bytes_remaining == '0) begin
            if (fill_count < FW'(lpd_pkg::HDR_BYTES)) begin
              res.status = lpd_pkg::ST_NOT_READY;
            end else if (hdr == '0 || hdr[31]) begin
              res.status = lpd_pkg::ST_NOT_READY;
            end else if (hdr_too_big) begin
              res.status = lpd_pkg::ST_TOO_LARGE;
            end else if (hdr_short_fill) begin
              res.status = lpd_pkg::ST_NOT_READY;
            end else begin
              consume = 1'b1;
              len_sel = hdr[LW-1:0];
              rem_sel = hdr[LW-1:0];
            end
          end else begin
            consume = 1'b1;
          end
        end
        default: ;
      endcase
    end

    if (consume) begin
      res.status           = lpd_pkg::ST_BYTE;
      res.packet_byte      = eff[0];
      res.packet_length    = len_sel;
      res.last             = (rem_sel == LW'(1));
      bytes_remaining_next = rem_sel - LW'(1);
      current_length_next  = (rem_sel == LW'(1)) ? '0 : len_sel;
      read_pointer_next    = lpd_pkg::ring_add(read_pointer, AW'(1));
      if (fill_count != '0) begin
        fill_count_next = fill_count - FW'(1);
      end
      // Shift the window; refill its tail from the store when a byte is there.
      win_next[0] = eff[1];
      win_next[1] = eff[2];
      win_next[2] = eff[3];
      win_next[3] = eff[3];
      if (fill_count > FW'(lpd_pkg::HDR_BYTES)) begin
        req.re    = 1'b1;
        req.raddr = lpd_pkg::ring_add(read_pointer, AW'(lpd_pkg::HDR_BYTES));
        pend_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    win <= win_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend            <= 1'b0;
      read_pointer    <= '0;
      write_pointer   <= '0;
      fill_count      <= '0;
      bytes_remaining <= '0;
      current_length  <= '0;
    end else begin
      pend            <= pend_next;
      read_pointer    <= read_pointer_next;
      write_pointer   <= write_pointer_next;
      fill_count      <= fill_count_next;
      bytes_remaining <= bytes_remaining_next;
      current_length  <= current_length_next;
    end
  end

endmodule

// ----- design/lpd_out.sv -----
// Output register with a skid stage for the deframer result channel.
// Depends on lpd_pkg.
module lpd_out (
  input  logic             clk,
  input  logic             rst,
  input  logic             res_valid,
  input  lpd_pkg::result_t res,
  input  logic             result_stall,
  output logic             result_valid,
  output lpd_pkg::result_t result,
  output logic             item_stall
);

  logic             skid_valid;
  lpd_pkg::result_t skid;
  logic             take;

  assign take       = result_valid && !result_stall;
  assign item_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || take) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || take) begin
      result <= skid_valid ? skid : res;
    end else if (res_valid) begin
      skid <= res;
    end
  end

endmodule

// ----- design/lpd_check.sv -----
// Port-level checks for the deframer, bound to the top level.
// Depends on lpd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lpd_check (
  input logic                         clk,
  input logic                         rst,
  input logic                         result_valid,
  input logic                         result_stall,
  input logic [lpd_pkg::STATUS_W-1:0] status,
  input logic [7:0]                   packet_byte,
  input logic [lpd_pkg::LEN_W-1:0]    packet_length,
  input logic                         last
);

  logic is_byte;
  assign is_byte = (status == lpd_pkg::ST_BYTE);

  `ASSERT_CLK(a_hold_stalled, clk, rst, result_valid && result_stall |=> result_valid && $stable(status) && $stable(packet_byte) && $stable(last))
  `ASSERT_CLK(a_non_byte_zero, clk, rst, result_valid && !is_byte |-> packet_byte == 8'd0 && packet_length == '0 && last == 1'b0)
  `ASSERT_CLK(a_byte_has_length, clk, rst, result_valid && is_byte |-> packet_length != '0)
  `ASSERT_ALWAYS(a_reset_empty, clk, $past(rst) |-> !result_valid)

endmodule

bind length_prefixed_packet_deframer_core lpd_check u_lpd_check (
  .clk           (clk),
  .rst           (rst),
  .result_valid  (result_valid),
  .result_stall  (result_stall),
  .status        (status),
  .packet_byte   (packet_byte),
  .packet_length (packet_length),
  .last          (last)
);

// ----- bench/tb_length_prefixed_packet_deframer_core.sv -----
// Self-checking bench for length_prefixed_packet_deframer_core: a directed table,
// a full-store pass, randomised framed traffic under several limits and a final
// stuck header. Depends on lpd_pkg and the deframer RTL only.
`timescale 1ns / 1ps

module tb_length_prefixed_packet_deframer_core;
  import lpd_pkg::*;

  localparam int NUM_DIRECTED    = 28;
  localparam int RANDOM_ITEMS    = 1050;
  localparam int SUB_PHASES      = 6;
  localparam int HOLD_CYCLES     = 80;
  localparam int END_CYCLES      = 16;
  localparam int WATCHDOG_CYCLES = 2000;
  localparam int MAX_REPORTS     = 10;
  localparam logic [LEN_W-1:0] LIMIT_TOP = 17'h10000;

  // One result word as the block presents it.
  typedef struct {
    status_t          status;
    logic [7:0]       data;
    logic [LEN_W-1:0] pkt_len;
    logic             last;
  } deframe_word_t;

  // One row of the directed table; want is used only when typed is set.
  typedef struct {
    op_t           op;
    logic [7:0]    data;
    bit            typed;
    deframe_word_t want;
  } dir_row_t;

  logic                clk;
  logic                rst;
  logic                item_valid;
  logic                item_stall;
  logic                operation;
  logic [7:0]          data_byte;
  logic                result_valid;
  logic                result_stall;
  logic [STATUS_W-1:0] status;
  logic [7:0]          packet_byte;
  logic [LEN_W-1:0]    packet_length;
  logic                last;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [LEN_W-1:0]    cfg_limit;

  // Shadow of the deframer state, advanced once per accepted item.
  logic [7:0]        store_shadow [BUF_DEPTH];
  logic [ADDR_W-1:0] head_ptr = '0;
  logic [ADDR_W-1:0] tail_ptr = '0;
  logic [FILL_W-1:0] held = '0;
  logic [LEN_W-1:0]  left_in_packet = '0;
  logic [LEN_W-1:0]  packet_len = '0;
  logic [LEN_W-1:0]  limit_reg = MAX_LEN_RESET;

  deframe_word_t words_due [$];   // results predicted but not yet seen
  logic [7:0]    tx_stream [$];   // framed bytes still to be written
  deframe_word_t blank_word;
  int            fault_count = 0;
  int            quiet_cycles = 0;
  bit            calm = 1'b0;            // no idling on either side
  bit            hold_request = 1'b0;    // ask the receiver for a long hold-off

  dir_row_t directed_rows [NUM_DIRECTED] = '{
    '{OP_READ,  8'h00, 1'b1, '{ST_NOT_READY, 8'h00, 17'd0, 1'b0}},  // empty after reset
    '{OP_WRITE, 8'h00, 1'b1, '{ST_WRITE_OK,  8'h00, 17'd0, 1'b0}},
    '{OP_WRITE, 8'h00, 1'b0, '{ST_BYTE,      8'h00, 17'd0, 1'b0}},
    '{OP_WRITE, 8'h00, 1'b0, '{ST_BYTE,      8'h00, 17'd0, 1'b0}},
    '{OP_READ,  8'hFF, 1'b1, '{ST_NOT_READY, 8'h00, 17'd0, 1'b0}},  // three header bytes
    '{OP_WRITE, 8'h06, 1'b0, '{ST_BYTE,      8'h00, 17'd0, 1'b0}},
    '{OP_WRITE, 8'hFF, 1'b0, '{ST_BYTE,      8'h00, 17'd0, 1'b0}},
    '{OP_READ,  8'h00, 1'b1, '{ST_NOT_READY, 8'h00, 17'd0, 1'b0}},  // five of six held
    '{OP_WRITE, 8'h01, 1'b0, '{ST_BYTE,      8'h00, 17'd0, 1'b0}},
    '{OP_WRITE, 8'h00, 1'b0, '{ST_BYTE,      8'h00, 17'd0, 1'b0}},  // next header opens
    '{OP_READ,  8'h00, 1'b1, '{ST_BYTE,      8'h00, 17'd6, 1'b0}},
    '{OP_READ,  8'h00, 1'b0, '{ST_BYTE,      8'h00, 17'd0, 1'b0}},
    '{OP_READ,  8'h00, 1'b0, '{ST_BYTE,      8'h00, 17'd0, 1'b0}},
    '{OP_READ,  8'h00, 1'b0, '{ST_BYTE,      8'h00, 17'd0, 1'b0}},
    '{OP_READ,  8'h00, 1'b0, '{ST_BYTE,      8'h00, 17'd0, 1'b0}},
    '{OP_READ,  8'h00, 1'b1, '{ST_BYTE,      8'h01, 17'd6, 1'b1}},
    '{OP_WRITE, 8'h00, 1'b0, '{ST_BYTE,      8'h00, 17'd0, 1'b0}},
    '{OP_WRITE, 8'h00, 1'b0, '{ST_BYTE,      8'h00, 17'd0, 1'b0}},
    '{OP_WRITE, 8'h04, 1'b0, '{ST_BYTE,      8'h00, 17'd0, 1'b0}},  // header-only packet
    '{OP_READ,  8'h00, 1'b0, '{ST_BYTE,      8'h00, 17'd0, 1'b0}},
    '{OP_READ,  8'h00, 1'b0, '{ST_BYTE,      8'h00, 17'd0, 1'b0}},
    '{OP_READ,  8'h00, 1'b0, '{ST_BYTE,      8'h00, 17'd0, 1'b0}},
    '{OP_READ,  8'h00, 1'b1, '{ST_BYTE,      8'h04, 17'd4, 1'b1}},
    '{OP_WRITE, 8'h00, 1'b0, '{ST_BYTE,      8'h00, 17'd0, 1'b0}},
    '{OP_WRITE, 8'h00, 1'b0, '{ST_BYTE,      8'h00, 17'd0, 1'b0}},
    '{OP_WRITE, 8'h10, 1'b0, '{ST_BYTE,      8'h00, 17'd0, 1'b0}},
    '{OP_WRITE, 8'h00, 1'b0, '{ST_BYTE,      8'h00, 17'd0, 1'b0}},
    '{OP_READ,  8'h00, 1'b1, '{ST_TOO_LARGE, 8'h00, 17'd0, 1'b0}}   // 4096 at the reset limit
  };

  length_prefixed_packet_deframer_core dut (
    .clk               (clk),
    .rst               (rst),
    .item_valid        (item_valid),
    .item_stall        (item_stall),
    .operation         (operation),
    .data_byte         (data_byte),
    .result_valid      (result_valid),
    .result_stall      (result_stall),
    .status            (status),
    .packet_byte       (packet_byte),
    .packet_length     (packet_length),
    .last              (last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .max_packet_length (cfg_limit)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advance the shadow state by one item and return the word it must produce.
  function automatic deframe_word_t predict_deframe(input op_t op, input logic [7:0] b);
    deframe_word_t w;
    logic [31:0]   raw;
    int            k;
    w.status  = ST_BYTE;
    w.data    = '0;
    w.pkt_len = '0;
    w.last    = 1'b0;
    if (op == OP_WRITE) begin
      if (held == FILL_W'(BUF_DEPTH)) begin
        w.status = ST_FULL;
      end else begin
        store_shadow[tail_ptr] = b;
        tail_ptr = (tail_ptr == ADDR_W'(BUF_DEPTH - 1)) ? '0 : tail_ptr + 1'b1;
        held = held + 1'b1;
        w.status = ST_WRITE_OK;
      end
      return w;
    end
    // At a packet start: decode the big-endian header in place, without skipping it.
    if (left_in_packet == '0) begin
      if (held < FILL_W'(HDR_BYTES)) begin
        w.status = ST_NOT_READY;
        return w;
      end
      raw = '0;
      for (k = 0; k < HDR_BYTES; k++) begin
        raw = {raw[23:0], store_shadow[(int'(head_ptr) + k) % BUF_DEPTH]};
      end
      if (raw == '0 || raw[31]) begin
        w.status = ST_NOT_READY;
        return w;
      end
      if (raw >= 32'(limit_reg)) begin
        w.status = ST_TOO_LARGE;
        return w;
      end
      if (32'(held) < raw) begin
        w.status = ST_NOT_READY;
        return w;
      end
      packet_len     = raw[LEN_W-1:0];
      left_in_packet = raw[LEN_W-1:0];
    end
    w.data    = store_shadow[head_ptr];
    w.pkt_len = packet_len;
    head_ptr  = (head_ptr == ADDR_W'(BUF_DEPTH - 1)) ? '0 : head_ptr + 1'b1;
    if (held != '0) begin
      held = held - 1'b1;
    end
    left_in_packet = left_in_packet - 1'b1;
    if (left_in_packet == '0) begin
      w.last     = 1'b1;
      packet_len = '0;
    end
    return w;
  endfunction

  // Offer one word, hold it until taken, then log the result it is owed.
  task automatic send_word(input op_t op, input logic [7:0] b, input bit typed,
                           input deframe_word_t want, output status_t got);
    deframe_word_t w;
    if (!calm && $urandom_range(0, 7) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    item_valid <= 1'b1;
    operation  <= op;
    data_byte  <= b;
    do @(posedge clk); while (item_stall);
    w = predict_deframe(op, b);
    got = w.status;
    words_due.push_back(typed ? want : w);
  endtask

  // Drop valid and let every owed word drain before touching the limit.
  task automatic settle();
    item_valid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LEN_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_limit <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    limit_reg = value;
  endtask

  // Append one well-formed packet to the byte stream.
  task automatic queue_packet();
    int pick;
    int plen;
    int k;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      // A length-one packet: its last three header bytes open a 256+ packet.
      plen = 256 + $urandom_range(0, 31);
      tx_stream.push_back(8'h00);
      tx_stream.push_back(8'h00);
      tx_stream.push_back(8'h00);
      tx_stream.push_back(8'h01);
      tx_stream.push_back(8'(plen));
    end else begin
      if (pick < 14) begin
        plen = 4;
      end else if (pick < 22) begin
        plen = $urandom_range(65, 300);
      end else begin
        plen = $urandom_range(5, 40);
      end
      tx_stream.push_back(8'h00);
      tx_stream.push_back(8'h00);
      tx_stream.push_back(8'(plen >> 8));
      tx_stream.push_back(8'(plen));
    end
    for (k = 4; k < plen; k++) begin
      tx_stream.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // Write the next framed byte or read, keeping the stream intact on a refusal.
  task automatic random_step(input bit refill);
    status_t st;
    if (refill && tx_stream.size() == 0) begin
      queue_packet();
    end
    if (tx_stream.size() != 0 && $urandom_range(0, 99) < 55) begin
      send_word(OP_WRITE, tx_stream[0], 1'b0, blank_word, st);
      if (st == ST_WRITE_OK) begin
        void'(tx_stream.pop_front());
      end
    end else begin
      send_word(OP_READ, 8'($urandom_range(0, 255)), 1'b0, blank_word, st);
    end
  endtask

  // Receiver: random stall bursts, or one long hold-off on request.
  initial begin
    result_stall <= 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        result_stall <= 1'b0;
        hold_request = 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  // Compare every accepted result against the oldest owed word.
  always @(posedge clk) begin : check_results
    deframe_word_t due;
    if (!rst && result_valid && !result_stall) begin
      if (words_due.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS) begin
          $display("unexpected result: status %0d byte %02h len %0d last %0b",
                   status, packet_byte, packet_length, last);
        end
      end else begin
        due = words_due.pop_front();
        if (status !== due.status || packet_byte !== due.data ||
            packet_length !== due.pkt_len || last !== due.last) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS) begin
            $display("mismatch: want status %0d byte %02h len %0d last %0b, got %0d %02h %0d %0b",
                     due.status, due.data, due.pkt_len, due.last,
                     status, packet_byte, packet_length, last);
          end
        end
      end
    end
  end

  // Abort when no channel has moved a word for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
          (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [LEN_W-1:0] limit_plan [SUB_PHASES];
    status_t          st;
    int               i;
    int               p;
    rst        <= 1'b1;
    item_valid <= 1'b0;
    operation  <= OP_WRITE;
    data_byte  <= 8'h00;
    cfg_valid  <= 1'b0;
    cfg_limit  <= MAX_LEN_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table at the reset limit.
    for (i = 0; i < NUM_DIRECTED; i++) begin
      send_word(directed_rows[i].op, directed_rows[i].data, directed_rows[i].typed,
                directed_rows[i].want, st);
    end

    // Complete the 4096-byte packet, fill the store, then push one byte too many.
    for (i = 0; i < BUF_DEPTH - HDR_BYTES; i++) begin
      send_word(OP_WRITE, 8'($urandom_range(0, 255)), 1'b0, blank_word, st);
    end
    send_word(OP_WRITE, 8'hA5, 1'b0, blank_word, st);
    send_word(OP_READ, 8'h00, 1'b0, blank_word, st);
    settle();
    write_limit(LIMIT_TOP);
    // Drain the whole store as one packet; every entry is now written.
    for (i = 0; i < BUF_DEPTH; i++) begin
      send_word(OP_READ, 8'($urandom_range(0, 255)), 1'b0, blank_word, st);
    end

    // Framed traffic under a run of limits, the lowest and highest among them.
    limit_plan[0] = LIMIT_TOP;
    limit_plan[1] = 17'd1;
    limit_plan[2] = LEN_W'($urandom_range(5, 64));
    limit_plan[3] = MAX_LEN_RESET;
    limit_plan[4] = LEN_W'($urandom_range(40, 400));
    limit_plan[5] = 17'd300;
    for (p = 0; p < SUB_PHASES; p++) begin
      settle();
      write_limit(limit_plan[p]);
      if (p == 0) begin
        // Hold the receiver off while items keep coming, so the input backs up.
        hold_request = 1'b1;
      end
      for (i = 0; i < RANDOM_ITEMS / SUB_PHASES; i++) begin
        random_step(1'b1);
      end
    end

    // Last part: no idling; finish the stream and empty the store.
    calm = 1'b1;
    settle();
    write_limit(LIMIT_TOP);
    while (tx_stream.size() != 0 || held != '0) begin
      random_step(1'b0);
    end

    // A negative header blocks the head for good, so it closes the run.
    for (i = 0; i < HDR_BYTES; i++) begin
      send_word(OP_WRITE, 8'hFF, 1'b0, blank_word, st);
    end
    send_word(OP_READ, 8'h00, 1'b0, blank_word, st);
    send_word(OP_WRITE, 8'h00, 1'b0, blank_word, st);
    send_word(OP_READ, 8'h00, 1'b0, blank_word, st);

    item_valid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    if (fault_count == 0 && words_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
